// ===== hdl/dar_pkg.sv =====
// shared types, constants and angle table for the dial reading pipeline
// no dependencies
`timescale 1ns / 1ps
package dar_pkg;

  localparam int COORD_FRAC_BITS = 4;
  localparam int CORDIC_STEPS    = 16;
  localparam int VEC_W           = 40;
  localparam int ANG_W           = 20;
  localparam int SWEEP_W         = 22;
  localparam int NUM_W           = SWEEP_W + 16;
  localparam int QUO_W           = NUM_W;
  localparam int RATIO_W         = 20;

  localparam logic signed [ANG_W-1:0] HALF_PI = 20'sd102944;
  localparam logic signed [SWEEP_W-1:0] TWO_PI = 22'sd411775;
  localparam logic signed [RATIO_W-1:0] RATIO_MAX = 20'sd524287;
  localparam logic signed [RATIO_W-1:0] RATIO_MIN = 20'sh80000;

  localparam logic [0:0] REG_BEGIN = 1'b0;
  localparam logic [0:0] REG_END   = 1'b1;

  typedef struct packed {
    logic [15:0] center_x;
    logic [15:0] center_y;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [15:0] stop_x;
    logic [15:0] stop_y;
    logic [15:0] head_x;
    logic [15:0] head_y;
  } request_t;

  typedef struct packed {
    logic signed [31:0]         reading;
    logic signed [RATIO_W-1:0]  sweep_ratio;
  } result_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 20'sd51472;
      1: v = 20'sd30385;
      2: v = 20'sd16055;
      3: v = 20'sd8150;
      4: v = 20'sd4091;
      5: v = 20'sd2047;
      6: v = 20'sd1024;
      7: v = 20'sd512;
      8: v = 20'sd256;
      9: v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      16: v = 20'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/dar_cordic.sv =====
// pipelined vectoring cordic, one micro-rotation per stage
// depends on dar_pkg
`timescale 1ns / 1ps
module dar_cordic (
  input  logic                               clk,
  input  logic signed [16:0]                 dx,
  input  logic signed [16:0]                 dy,
  output logic signed [dar_pkg::ANG_W-1:0]   angle
);
  import dar_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [VEC_W-1:0] xs [0:N];
  logic signed [VEC_W-1:0] ys [0:N];
  logic signed [ANG_W-1:0] zs [0:N];
  logic                    zero_in;
  logic                    zero_q [0:N];
  logic signed [VEC_W-1:0] x0, y0;

  assign x0 = VEC_W'(dx) <<< (20 - COORD_FRAC_BITS);
  assign y0 = VEC_W'(dy) <<< (20 - COORD_FRAC_BITS);
  assign zero_in = (dx == '0) && (dy == '0);

  // pre-rotation into the right half plane
  always_ff @(posedge clk) begin
    zero_q[0] <= zero_in;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        xs[0] <= y0; ys[0] <= -x0; zs[0] <= HALF_PI;
      end else begin
        xs[0] <= -y0; ys[0] <= x0; zs[0] <= -HALF_PI;
      end
    end else begin
      xs[0] <= x0; ys[0] <= y0; zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      zero_q[i+1] <= zero_q[i];
      if (ys[i] > 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_entry(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_entry(i);
      end
    end
  end

  assign angle = zero_q[N] ? '0 : zs[N];
endmodule

// ===== hdl/dar_divider.sv =====
// pipelined restoring divider, one quotient bit per stage, magnitude form
// depends on dar_pkg
`timescale 1ns / 1ps
module dar_divider (
  input  logic                               clk,
  input  logic signed [dar_pkg::NUM_W-1:0]   num,
  input  logic signed [dar_pkg::SWEEP_W-1:0] den,
  output logic signed [dar_pkg::QUO_W:0]     quo
);
  import dar_pkg::*;

  localparam int N = NUM_W;

  logic [N-1:0]       nmag [0:N];
  logic [SWEEP_W-1:0] dmag [0:N];
  logic [SWEEP_W:0]   rem  [0:N];
  logic [N-1:0]       q    [0:N];
  logic               neg  [0:N];

  always_ff @(posedge clk) begin
    nmag[0] <= num[N-1] ? N'(-num) : N'(num);
    dmag[0] <= den[SWEEP_W-1] ? SWEEP_W'(-den) : SWEEP_W'(den);
    rem[0]  <= '0;
    q[0]    <= '0;
    neg[0]  <= num[N-1] ^ den[SWEEP_W-1];
  end

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [SWEEP_W+1:0] trial;
    assign trial = {rem[i], nmag[i][N-1-i]};
    always_ff @(posedge clk) begin
      nmag[i+1] <= nmag[i];
      dmag[i+1] <= dmag[i];
      neg[i+1]  <= neg[i];
      if (trial >= {2'b00, dmag[i]}) begin
        rem[i+1] <= (SWEEP_W+1)'(trial - {2'b00, dmag[i]});
        q[i+1]   <= q[i] | (N'(1) << (N-1-i));
      end else begin
        rem[i+1] <= trial[SWEEP_W:0];
        q[i+1]   <= q[i];
      end
    end
  end

  assign quo = neg[N] ? -$signed({1'b0, q[N]}) : $signed({1'b0, q[N]});
endmodule

// ===== hdl/dial_angle_to_reading.sv =====
// Each request gives one result on result, with done high for one cycle; the result passes
// through 17 cordic stages, one sweep stage, 39 divider stages and three scaling stages.
// busy never rises, so a request can be taken every cycle, and done cannot be held off.
// The scale registers are read near the end of the pipe, so write them only while no
// request is in flight.
// depends on dar_pkg, dar_cordic, dar_divider
`timescale 1ns / 1ps
module dial_angle_to_reading (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  dar_pkg::request_t    request,
  output logic                 done,
  output dar_pkg::result_t     result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);
  import dar_pkg::*;

  localparam int CL = CORDIC_STEPS + 1;
  localparam int DL = NUM_W + 1;
  localparam int LAT = CL + 1 + DL + 3;

  logic signed [31:0] begin_val, end_val;
  logic               acc;
  logic [LAT-1:0]     vld;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      begin_val <= '0;
      end_val   <= 32'sd6553600;
      vld       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BEGIN: begin_val <= cfg_data;
          REG_END:   end_val   <= cfg_data;
          default: ;
        endcase
      end
      vld <= {vld[LAT-2:0], acc};
    end
  end

  logic signed [16:0] sdx, sdy, edx, edy, hdx, hdy;
  assign sdx = 17'(request.start_x) - 17'(request.center_x);
  assign sdy = 17'(request.center_y) - 17'(request.start_y);
  assign edx = 17'(request.stop_x) - 17'(request.center_x);
  assign edy = 17'(request.center_y) - 17'(request.stop_y);
  assign hdx = 17'(request.head_x) - 17'(request.center_x);
  assign hdy = 17'(request.center_y) - 17'(request.head_y);

  logic signed [ANG_W-1:0] a_s, a_e, a_h;
  dar_cordic u_cs (.clk, .dx(sdx), .dy(sdy), .angle(a_s));
  dar_cordic u_ce (.clk, .dx(edx), .dy(edy), .angle(a_e));
  dar_cordic u_ch (.clk, .dx(hdx), .dy(hdy), .angle(a_h));

  // lower-left flag follows the cordic
  logic ll_q [0:CL-1];
  always_ff @(posedge clk) begin
    ll_q[0] <= (request.head_y > request.center_y) && (request.head_x < request.center_x);
    for (int i = 1; i < CL; i++) ll_q[i] <= ll_q[i-1];
  end

  logic signed [SWEEP_W-1:0] scale_sw, head_sw;
  always_ff @(posedge clk) begin
    scale_sw <= TWO_PI - (SWEEP_W'(a_e) - SWEEP_W'(a_s));
    if (ll_q[CL-1]) head_sw <= SWEEP_W'(a_s) - SWEEP_W'(a_h);
    else            head_sw <= TWO_PI - (SWEEP_W'(a_h) - SWEEP_W'(a_s));
  end

  logic signed [QUO_W:0] quo;
  dar_divider u_div (.clk, .num({head_sw, 16'd0}), .den(scale_sw), .quo(quo));

  logic zden_q [0:DL-1];
  logic hpos_q [0:DL-1];
  logic hneg_q [0:DL-1];
  always_ff @(posedge clk) begin
    zden_q[0] <= scale_sw == '0;
    hpos_q[0] <= head_sw > 0;
    hneg_q[0] <= head_sw < 0;
    for (int i = 1; i < DL; i++) begin
      zden_q[i] <= zden_q[i-1];
      hpos_q[i] <= hpos_q[i-1];
      hneg_q[i] <= hneg_q[i-1];
    end
  end

  logic signed [RATIO_W-1:0] ratio1, ratio2, ratio3;
  logic signed [32:0]        diff;
  logic signed [53:0]        prod;
  logic signed [37:0]        sum;
  logic signed [31:0]        begin2;
  always_ff @(posedge clk) begin
    if (zden_q[DL-1])
      ratio1 <= hpos_q[DL-1] ? RATIO_MAX : (hneg_q[DL-1] ? RATIO_MIN : '0);
    else if (quo > RATIO_MAX) ratio1 <= RATIO_MAX;
    else if (quo < RATIO_MIN) ratio1 <= RATIO_MIN;
    else ratio1 <= RATIO_W'(quo);
    diff   <= 33'(end_val) - 33'(begin_val);
    prod   <= 54'(diff) * 54'(ratio1);
    ratio2 <= ratio1;
    begin2 <= begin_val;
    sum    <= 38'(begin2) + 38'(prod >>> 16);
    ratio3 <= ratio2;
  end

  assign done = vld[LAT-1];
  assign result.sweep_ratio = ratio3;
  assign result.reading = (sum > 38'sd2147483647) ? 32'sh7fffffff :
                          (sum < -38'sd2147483648) ? 32'sh80000000 : 32'(sum);

  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_done: assert property (@(posedge clk) disable iff (rst) done |-> $past(vld[LAT-2]))
    else $error("done without request");
  a_rat: assert property (@(posedge clk) disable iff (rst) done |->
    (result.sweep_ratio <= RATIO_MAX)) else $error("ratio range");
endmodule
